/* design/des_pkg.sv */
// DES package: permutation tables, S-boxes, the stage payload type and
// the bit-permutation and round functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package des_pkg;

  localparam int unsigned NumRounds = 16;
  localparam int unsigned BlockW    = 64;
  localparam int unsigned HalfW     = 32;
  localparam int unsigned SubkeyW   = 48;
  localparam int unsigned KeyHalfW  = 28;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } des_op_e;

  typedef struct packed {
    des_op_e           op;
    logic [HalfW-1:0]  l;
    logic [HalfW-1:0]  r;
  } des_cell_t;

  typedef logic [SubkeyW-1:0] des_subkey_t;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // cumulative left rotation of C and D before each subkey
  localparam logic [4:0] ROT_TOTAL [16] = '{
    5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
  };

  localparam logic [3:0] SBOX [8][4][16] = '{
    '{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
      '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
      '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
      '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
    '{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
      '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
      '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
      '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
    '{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
      '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
      '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
      '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
    '{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
      '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
      '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
      '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
    '{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
      '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
      '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
      '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
    '{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
      '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
      '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
      '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
    '{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
      '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
      '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
      '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
    '{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
      '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
      '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
      '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}
  };

  // tables use DES numbering: position 1 is the MSB of the source word
  function automatic logic [63:0] ip_f(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[63-i] = x[64-int'(IP_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [63:0] fp_f(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[63-i] = x[64-int'(FP_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [47:0] e_f(input logic [31:0] x);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) begin
      r[47-i] = x[32-int'(E_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [31:0] p_f(input logic [31:0] x);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[31-i] = x[32-int'(P_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [55:0] pc1_f(input logic [63:0] x);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) begin
      r[55-i] = x[64-int'(PC1_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [47:0] pc2_f(input logic [55:0] x);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) begin
      r[47-i] = x[56-int'(PC2_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [27:0] rot28_f(input logic [27:0] v, input logic [4:0] s);
    logic [55:0] t;
    t = {v, v} << s;
    return t[55:28];
  endfunction

  function automatic logic [31:0] feistel_f(input logic [31:0] r, input des_subkey_t k);
    logic [47:0] x;
    logic [5:0]  six;
    logic [31:0] s;
    x = e_f(r) ^ k;
    s = '0;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = SBOX[b][{six[5], six[0]}][six[4:1]];
    end
    return p_f(s);
  endfunction

endpackage

`default_nettype wire

/* design/des_key_sched.sv */
// DES key schedule: PC-1, fixed rotations of C and D, PC-2 for all
// sixteen subkeys. Depends on des_pkg.
`timescale 1ns / 1ps
`default_nettype none

module des_key_sched (
  input  logic [63:0]         key_i,
  output des_pkg::des_subkey_t subkey_o [des_pkg::NumRounds]
);
  import des_pkg::*;

  logic [55:0] cd;
  logic [27:0] c_half;
  logic [27:0] d_half;

  assign cd     = pc1_f(key_i);
  assign c_half = cd[55:28];
  assign d_half = cd[27:0];

  for (genvar g = 0; g < NumRounds; g++) begin : g_sub
    assign subkey_o[g] = pc2_f({rot28_f(c_half, ROT_TOTAL[g]),
                                rot28_f(d_half, ROT_TOTAL[g])});
  end

endmodule

`default_nettype wire

/* design/des_round_cell.sv */
// One registered DES Feistel round stage with its own valid and
// backpressure. Depends on des_pkg.
`timescale 1ns / 1ps
`default_nettype none

module des_round_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  des_pkg::des_cell_t   data_i,
  input  des_pkg::des_subkey_t key_enc_i,
  input  des_pkg::des_subkey_t key_dec_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output des_pkg::des_cell_t   data_o
);
  import des_pkg::*;

  logic        valid_q;
  des_cell_t   data_q;
  des_cell_t   data_d;
  des_subkey_t key;

  assign ready_o = !valid_q || ready_i;
  assign key     = (data_i.op == OP_DECRYPT) ? key_dec_i : key_enc_i;

  always_comb begin
    data_d.op = data_i.op;
    data_d.l  = data_i.r;
    data_d.r  = data_i.l ^ feistel_f(data_i.r, key);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // advance payload only with a beat
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* design/des_block_cipher_core.sv */
// DES core top level: key register, IP, chain of sixteen round cells,
// FP. Depends on des_pkg, des_key_sched and des_round_cell.
// Pipeline: one register per round between input beat and output beat.
// Throughput: one block per cycle; each round cell stalls only when full
// and its successor is stalled.
// Reset: clears all stage valid bits and the key register to zero.
`timescale 1ns / 1ps
`default_nettype none

module des_block_cipher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i,    // cipher_key
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // block_in
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // block_out
);
  import des_pkg::*;

  logic [63:0] key_q;
  des_subkey_t subkey [NumRounds];

  logic        valid_s [NumRounds+1];
  logic        ready_s [NumRounds+1];
  des_cell_t   data_s  [NumRounds+1];
  logic [63:0] ip_blk;
  des_cell_t   last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i) begin
      key_q <= cfg_data_i;
    end
  end

  des_key_sched u_key_sched (
    .key_i    (key_q),
    .subkey_o (subkey)
  );

  assign ip_blk       = ip_f(s_axis_tdata);
  assign data_s[0].op = des_op_e'(s_axis_tuser);
  assign data_s[0].l  = ip_blk[63:32];
  assign data_s[0].r  = ip_blk[31:0];
  assign valid_s[0]   = s_axis_tvalid;
  assign s_axis_tready = ready_s[0];

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    des_round_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (valid_s[g]),
      .ready_o   (ready_s[g]),
      .data_i    (data_s[g]),
      .key_enc_i (subkey[g]),
      .key_dec_i (subkey[NumRounds-1-g]),
      .valid_o   (valid_s[g+1]),
      .ready_i   (ready_s[g+1]),
      .data_o    (data_s[g+1])
    );
  end

  assign last                = data_s[NumRounds];
  assign ready_s[NumRounds]  = m_axis_tready;
  assign m_axis_tvalid       = valid_s[NumRounds];
  // swap halves after the last round
  assign m_axis_tdata        = fp_f({last.r, last.l});

endmodule

`default_nettype wire
